/* src/dual_loop_step_sequencer_assert.svh */
// assertion macros for the step sequencer checker
`ifndef DUAL_LOOP_STEP_SEQUENCER_ASSERT_SVH
`define DUAL_LOOP_STEP_SEQUENCER_ASSERT_SVH

// overlapping implication under clk, off while reset is asserted
`define DLSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dlss check failed");

// non-overlapping implication under clk, off while reset is asserted
`define DLSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dlss check failed");

`endif

/* src/dlss_pkg.sv */
package dlss_pkg;

	localparam int unsigned COL_W = 4;
	localparam int unsigned END_W = 5;
	localparam int unsigned NUM_COLS = 16;
	localparam int unsigned NUM_ROWS = 4;
	localparam int unsigned NARROW_COLUMNS = 8;

	localparam logic REQ_STEP = 1'b0;
	localparam logic REQ_KEY = 1'b1;

	localparam logic [2:0] ROW_START_ONE = 3'd0;
	localparam logic [2:0] ROW_END_ONE = 3'd1;
	localparam logic [2:0] ROW_START_TWO = 3'd2;
	localparam logic [2:0] ROW_END_TWO = 3'd3;

	typedef struct packed {
		logic [COL_W-1:0] start;
		logic [END_W-1:0] end_col;
		logic [END_W-1:0] length;
		logic [COL_W-1:0] head;
	} loop_t;

	typedef struct packed {
		logic [END_W-1:0] end_from_start;
		logic [END_W-1:0] length_from_end;
	} edit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_FINISH
	} state_t;

endpackage

/* src/dlss_step.sv */
module dlss_step (
	input  dlss_pkg::loop_t              loop_in,
	input  logic [dlss_pkg::END_W-1:0]   grid,
	input  logic                         backward,
	output logic [dlss_pkg::COL_W-1:0]   head_next
);
	import dlss_pkg::*;

	logic [END_W-1:0] head_ext;
	logic [END_W-1:0] head_inc;
	logic [END_W-1:0] grid_last;

	assign head_ext = {1'b0, loop_in.head};
	assign head_inc = head_ext + END_W'(1);
	assign grid_last = grid - END_W'(1);

	always_comb begin
		if (!backward) begin
			if (head_ext == loop_in.end_col) begin
				head_next = loop_in.start;
			end else if (head_inc >= grid) begin
				head_next = '0;
			end else begin
				head_next = head_inc[COL_W-1:0];
			end
		end else begin
			if (loop_in.head == loop_in.start) begin
				if (loop_in.end_col >= grid) begin
					head_next = grid_last[COL_W-1:0];
				end else begin
					head_next = loop_in.end_col[COL_W-1:0];
				end
			end else if (loop_in.head == '0) begin
				head_next = grid_last[COL_W-1:0];
			end else begin
				head_next = loop_in.head - COL_W'(1);
			end
		end
	end

endmodule

/* src/dlss_edit.sv */
module dlss_edit (
	input  dlss_pkg::loop_t              loop_in,
	input  logic [dlss_pkg::COL_W-1:0]   column,
	input  logic [dlss_pkg::END_W-1:0]   grid,
	output dlss_pkg::edit_t              edit
);
	import dlss_pkg::*;

	logic [END_W:0]        end_sum;
	logic [END_W:0]        end_wrap;
	logic signed [END_W+1:0] diff;
	logic signed [END_W+1:0] diff_a;
	logic signed [END_W+1:0] diff_b;
	logic signed [END_W+1:0] grid_s;

	assign end_sum = {2'b00, column} + {1'b0, loop_in.length};
	assign end_wrap = (end_sum >= {1'b0, grid}) ? end_sum - {1'b0, grid} : end_sum;

	assign grid_s = $signed({2'b00, grid});
	assign diff = $signed({3'b000, column}) - $signed({3'b000, loop_in.start});
	assign diff_a = (diff < 0) ? diff + grid_s : diff;
	assign diff_b = (diff_a < 0) ? diff_a + grid_s : diff_a;

	assign edit.end_from_start = end_wrap[END_W-1:0];
	assign edit.length_from_end = diff_b[END_W-1:0];

endmodule

/* src/dual_loop_step_sequencer.sv */
// timing: a key event is applied in the cycle it is taken; a step event of count n passes
// through the move state (skipped if n is 0), then waits in the finish state while stalled
// each playhead has its own step unit and moves one column per cycle in the move state
// input is stalled from a step event until its result is loaded into the output register
// reset: asynchronous, pattern cleared, loops span the full grid, wide grid selected
module dual_loop_step_sequencer #(
	parameter int unsigned MAX_COLUMNS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          wide_grid,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic signed [7:0]             step_count,
	input  logic [dlss_pkg::COL_W-1:0]    key_column,
	input  logic [2:0]                    key_row,
	input  logic                          key_down,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [3:0]                    pattern_one,
	output logic [dlss_pkg::COL_W-1:0]    position_one,
	output logic [3:0]                    pattern_two,
	output logic [dlss_pkg::COL_W-1:0]    position_two
);
	import dlss_pkg::*;

	state_t             state_q;
	state_t             state_d;
	logic               wide_q;
	logic [END_W-1:0]   grid;
	logic [NUM_COLS-1:0] pattern_row_q [NUM_ROWS];
	loop_t              loop_one_q;
	loop_t              loop_two_q;
	logic               hold_one_q;
	logic               hold_two_q;
	logic               move_one_q;
	logic               move_two_q;
	logic               backward_q;
	logic [7:0]         count_q;
	logic [7:0]         step_mag;
	logic               in_acc;
	logic               out_free;
	logic               out_valid_q;
	logic [3:0]         pattern_one_q;
	logic [3:0]         pattern_two_q;
	logic [COL_W-1:0]   position_one_q;
	logic [COL_W-1:0]   position_two_q;
	logic [COL_W-1:0]   next_one;
	logic [COL_W-1:0]   next_two;
	logic [3:0]         col_one;
	logic [3:0]         col_two;
	loop_t              edit_loop;
	edit_t              edit;

	assign cfg_ready = 1'b1;
	assign grid = wide_q ? END_W'(MAX_COLUMNS) : END_W'(NARROW_COLUMNS);
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign step_mag = step_count[7] ? (~$unsigned(step_count) + 8'd1) : $unsigned(step_count);

	assign out_valid = out_valid_q;
	assign pattern_one = pattern_one_q;
	assign pattern_two = pattern_two_q;
	assign position_one = position_one_q;
	assign position_two = position_two_q;

	assign edit_loop = key_row[1] ? loop_two_q : loop_one_q;

	dlss_edit u_edit (
		.loop_in (edit_loop),
		.column  (key_column),
		.grid    (grid),
		.edit    (edit)
	);

	dlss_step u_step_one (
		.loop_in   (loop_one_q),
		.grid      (grid),
		.backward  (backward_q),
		.head_next (next_one)
	);

	dlss_step u_step_two (
		.loop_in   (loop_two_q),
		.grid      (grid),
		.backward  (backward_q),
		.head_next (next_two)
	);

	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			col_one[r] = pattern_row_q[r][loop_one_q.head];
			col_two[r] = pattern_row_q[r][loop_two_q.head];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (req_type == REQ_STEP)) begin
					state_d = (step_mag == 8'd0) ? ST_FINISH : ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (count_q == 8'd1) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			wide_q <= wide_grid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				pattern_row_q[r] <= '0;
			end
			loop_one_q <= '{start: '0, end_col: END_W'(MAX_COLUMNS),
				length: END_W'(MAX_COLUMNS), head: '0};
			loop_two_q <= '{start: '0, end_col: END_W'(MAX_COLUMNS),
				length: END_W'(MAX_COLUMNS), head: '0};
			hold_one_q <= 1'b0;
			hold_two_q <= 1'b0;
			move_one_q <= 1'b0;
			move_two_q <= 1'b0;
			backward_q <= 1'b0;
			count_q <= '0;
		end else if (in_acc && (req_type == REQ_KEY)) begin
			if (key_down) begin
				case (key_row)
					ROW_START_ONE: begin
						loop_one_q.start <= key_column;
						loop_one_q.head <= key_column;
						loop_one_q.end_col <= edit.end_from_start;
						hold_one_q <= 1'b1;
					end
					ROW_END_ONE: begin
						loop_one_q.end_col <= {1'b0, key_column};
						loop_one_q.length <= edit.length_from_end;
					end
					ROW_START_TWO: begin
						loop_two_q.start <= key_column;
						loop_two_q.head <= key_column;
						loop_two_q.end_col <= edit.end_from_start;
						hold_two_q <= 1'b1;
					end
					ROW_END_TWO: begin
						loop_two_q.end_col <= {1'b0, key_column};
						loop_two_q.length <= edit.length_from_end;
					end
					default: begin
						pattern_row_q[key_row[1:0]][key_column] <=
							~pattern_row_q[key_row[1:0]][key_column];
					end
				endcase
			end
		end else if (in_acc) begin
			move_one_q <= ~hold_one_q;
			move_two_q <= ~hold_two_q;
			hold_one_q <= 1'b0;
			hold_two_q <= 1'b0;
			backward_q <= step_count[7];
			count_q <= step_mag;
		end else if (state_q == ST_MOVE) begin
			if (move_one_q) begin
				loop_one_q.head <= next_one;
			end
			if (move_two_q) begin
				loop_two_q.head <= next_two;
			end
			count_q <= count_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, captured when the step finishes
	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			pattern_one_q <= col_one;
			pattern_two_q <= col_two;
			position_one_q <= loop_one_q.head;
			position_two_q <= loop_two_q.head;
		end
	end

endmodule

/* src/dlss_checker.sv */
`include "dual_loop_step_sequencer_assert.svh"

module dlss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         req_type,
	input logic signed [7:0]            step_count,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [3:0]                   pattern_one,
	input logic [dlss_pkg::COL_W-1:0]   position_one,
	input logic [3:0]                   pattern_two,
	input logic [dlss_pkg::COL_W-1:0]   position_two
);
	import dlss_pkg::*;

	logic                        in_acc;
	logic                        out_hold;
	logic                        zero_step;
	logic [8+2*COL_W-1:0]        out_payload;

	assign in_acc = in_valid & ~in_stall;
	assign out_hold = out_valid & out_stall;
	assign zero_step = in_acc && (req_type == REQ_STEP) && (step_count == 8'sd0);
	assign out_payload = {pattern_one, position_one, pattern_two, position_two};

	// a stalled result transaction keeps its payload
	`DLSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, out_valid && $stable(out_payload))

	// key events never make the block busy
	`DLSS_ASSERT_NEXT(a_key_ready, clk, arst_n, in_acc && (req_type == REQ_KEY), !in_stall)

	// a step event occupies the block
	`DLSS_ASSERT_NEXT(a_step_busy, clk, arst_n, in_acc && (req_type == REQ_STEP), in_stall)

	// zero-count step taken while the output is empty reaches the output via the finish state
	`DLSS_ASSERT_NOW(a_zero_step, clk, arst_n, zero_step && !out_valid, ##2 out_valid)

endmodule

bind dual_loop_step_sequencer dlss_checker u_dlss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.req_type     (req_type),
	.step_count   (step_count),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pattern_one  (pattern_one),
	.position_one (position_one),
	.pattern_two  (pattern_two),
	.position_two (position_two)
);

/* sim/dual_loop_step_sequencer_tb.sv */
`default_nettype none

module dual_loop_step_sequencer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import dlss_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 140;
	localparam logic KEY_PRESS = 1'b1;
	localparam logic KEY_RELEASE = 1'b0;
	localparam logic GRID_NARROW = 1'b0;
	localparam logic GRID_WIDE = 1'b1;
	localparam logic [2:0] ROW_PATTERN_FIRST = 3'd4;
	localparam logic [2:0] ROW_PATTERN_LAST = 3'd7;

	typedef struct packed {
		logic [3:0] pattern_one;
		logic [3:0] position_one;
		logic [3:0] pattern_two;
		logic [3:0] position_two;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic wide_grid = GRID_WIDE;
	logic in_valid = 1'b0;
	logic req_type = REQ_STEP;
	logic signed [7:0] step_count = '0;
	logic [COL_W-1:0] key_column = '0;
	logic [2:0] key_row = '0;
	logic key_down = KEY_RELEASE;
	logic out_stall = 1'b0;

	wire cfg_ready;
	wire in_stall;
	wire out_valid;
	wire [3:0] pattern_one;
	wire [COL_W-1:0] position_one;
	wire [3:0] pattern_two;
	wire [COL_W-1:0] position_two;

	// sequencer state as predicted from accepted transactions
	logic [3:0] pattern_cols [NUM_COLS];
	loop_t loop_state [2];
	bit hold_pending [2];
	bit grid_wide;
	step_result_t step_results_due [$];

	int mismatches = 0;
	int cycle_count = 0;
	int in_gap_pct = 0;
	int out_stall_pct = 0;
	int stall_left = 0;

	dual_loop_step_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.wide_grid    (wide_grid),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.step_count   (step_count),
		.key_column   (key_column),
		.key_row      (key_row),
		.key_down     (key_down),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pattern_one  (pattern_one),
		.position_one (position_one),
		.pattern_two  (pattern_two),
		.position_two (position_two)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int grid_columns();
		return grid_wide ? int'(NUM_COLS) : int'(NARROW_COLUMNS);
	endfunction

	function automatic void clear_sequencer();
		foreach (pattern_cols[i]) pattern_cols[i] = '0;
		for (int p = 0; p < 2; p++) begin
			loop_state[p].start = '0;
			loop_state[p].end_col = END_W'(NUM_COLS);
			loop_state[p].length = END_W'(NUM_COLS);
			loop_state[p].head = '0;
			hold_pending[p] = 1'b0;
		end
		grid_wide = GRID_WIDE;
	endfunction

	function automatic void place_loop_start(int p, logic [3:0] col);
		int g;
		int e;
		g = grid_columns();
		e = int'(col) + int'(loop_state[p].length);
		if (e > g - 1) e -= g;
		loop_state[p].start = col;
		loop_state[p].head = col;
		loop_state[p].end_col = e[END_W-1:0];
		hold_pending[p] = 1'b1;
	endfunction

	function automatic void place_loop_end(int p, logic [3:0] col);
		int g;
		int d;
		g = grid_columns();
		d = int'(col) - int'(loop_state[p].start);
		if (d < 0) d += g;
		if (d < 0) d += g;
		loop_state[p].end_col = END_W'(col);
		loop_state[p].length = d[END_W-1:0];
	endfunction

	function automatic void advance_playhead(int p, int count);
		int g;
		int h;
		int e;
		int s;
		g = grid_columns();
		h = int'(loop_state[p].head);
		e = int'(loop_state[p].end_col);
		s = int'(loop_state[p].start);
		if (count > 0) begin
			for (int i = 0; i < count; i++) begin
				if (h == e) begin
					h = s;
				end else begin
					h++;
					if (h >= g) h = 0;
				end
			end
		end else begin
			for (int i = count; i < 0; i++) begin
				if (h == s) h = (e >= g) ? g - 1 : e;
				else if (h == 0) h = g - 1;
				else h--;
			end
		end
		loop_state[p].head = h[3:0];
	endfunction

	function automatic void apply_transaction(logic rt, logic signed [7:0] cnt,
			logic [3:0] col, logic [2:0] row, logic kd);
		step_result_t res;
		int count;
		if (rt == REQ_KEY) begin
			if (kd == KEY_PRESS) begin
				case (row)
					ROW_START_ONE: place_loop_start(0, col);
					ROW_END_ONE: place_loop_end(0, col);
					ROW_START_TWO: place_loop_start(1, col);
					ROW_END_TWO: place_loop_end(1, col);
					default: pattern_cols[col][row[1:0]] = ~pattern_cols[col][row[1:0]];
				endcase
			end
			return;
		end
		count = cnt;
		for (int p = 0; p < 2; p++) begin
			if (!hold_pending[p]) advance_playhead(p, count);
			hold_pending[p] = 1'b0;
		end
		res.pattern_one = pattern_cols[loop_state[0].head];
		res.position_one = loop_state[0].head;
		res.pattern_two = pattern_cols[loop_state[1].head];
		res.position_two = loop_state[1].head;
		step_results_due.push_back(res);
	endfunction

	always @(posedge clk) begin
		int burst;
		burst = 0;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < out_stall_pct) begin
			burst = $urandom_range(0, 17);
			stall_left <= burst;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		step_result_t got;
		step_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.pattern_one = pattern_one;
			got.position_one = position_one;
			got.pattern_two = pattern_two;
			got.position_two = position_two;
			if (step_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected step result: pat1 %h pos1 %0d pat2 %h pos2 %0d",
						got.pattern_one, got.position_one, got.pattern_two,
						got.position_two);
			end else begin
				want = step_results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("step result mismatch: expected %h/%0d %h/%0d, got %h/%0d %h/%0d",
							want.pattern_one, want.position_one, want.pattern_two,
							want.position_two, got.pattern_one, got.position_one,
							got.pattern_two, got.position_two);
				end
			end
		end
	end

	// one transaction, with an optional idle burst ahead of it
	task automatic send_item(input logic rt, input logic signed [7:0] cnt,
			input logic [3:0] col, input logic [2:0] row, input logic kd);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < in_gap_pct) gap = $urandom_range(1, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		step_count <= cnt;
		key_column <= col;
		key_row <= row;
		key_down <= kd;
		do @(posedge clk); while (in_stall);
		apply_transaction(rt, cnt, col, row, kd);
	endtask

	task automatic send_step(input logic signed [7:0] cnt);
		send_item(REQ_STEP, cnt, 4'($urandom), 3'($urandom), 1'($urandom));
	endtask

	task automatic send_key(input logic [2:0] row, input logic [3:0] col, input logic kd);
		send_item(REQ_KEY, 8'($urandom), col, row, kd);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (step_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_grid_width(input logic wide);
		cfg_valid <= 1'b1;
		wide_grid <= wide;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		grid_wide = wide;
	endtask

	task automatic test_wide_grid_edges();
		in_gap_pct = 15;
		out_stall_pct = 15;
		send_step(8'sd0);
		send_key(ROW_PATTERN_FIRST, 4'd0, KEY_PRESS);
		send_key(ROW_PATTERN_LAST, 4'd15, KEY_PRESS);
		send_key(3'd5, 4'd15, KEY_RELEASE);
		send_step(8'sd1);
		send_step(-8'sd1);
		send_step(8'sd127);
		send_step(-8'sd128);
		send_key(ROW_START_ONE, 4'd3, KEY_PRESS);
		send_key(ROW_END_ONE, 4'd2, KEY_PRESS);
		send_key(ROW_START_TWO, 4'd15, KEY_PRESS);
		send_key(ROW_END_TWO, 4'd0, KEY_PRESS);
		send_step(8'sd5);
		send_step(-8'sd20);
	endtask

	task automatic test_narrow_grid_edges();
		settle_idle();
		write_grid_width(GRID_NARROW);
		send_key(3'd6, 4'd12, KEY_PRESS);
		send_step(8'sd3);
		send_key(ROW_START_ONE, 4'd10, KEY_PRESS);
		send_key(ROW_END_TWO, 4'd14, KEY_PRESS);
		send_step(-8'sd9);
		send_step(8'sd9);
		send_key(ROW_START_TWO, 4'd5, KEY_PRESS);
		send_key(ROW_END_ONE, 4'd4, KEY_PRESS);
		send_step(8'sd127);
		send_step(-8'sd128);
	endtask

	task automatic run_traffic(input int n_items, input logic wide, input int gap_pct,
			input int stall_pct);
		int sent;
		int pick;
		int span;
		logic signed [7:0] cnt;
		settle_idle();
		write_grid_width(wide);
		in_gap_pct = gap_pct;
		out_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				span = $urandom_range(0, 9);
				if (span < 6) cnt = 8'($urandom_range(0, 16) - 8);
				else if (span < 9) cnt = 8'($urandom);
				else cnt = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
				send_step(cnt);
				sent++;
			end else if (pick < 60) begin
				send_key(3'($urandom_range(0, 3)), 4'($urandom), KEY_PRESS);
				sent++;
			end else if (pick < 90) begin
				send_key(3'($urandom_range(4, 7)), 4'($urandom), KEY_PRESS);
				sent++;
			end else begin
				send_key(3'($urandom), 4'($urandom), KEY_RELEASE);
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(250, GRID_NARROW, 30, 30);
		run_traffic(150, GRID_WIDE, 0, 0);
		run_traffic(250, GRID_NARROW, 12, 10);
		run_traffic(150, GRID_WIDE, 20, 25);
	endtask

	task automatic test_quiet_finish();
		run_traffic(80, GRID_WIDE, 0, 0);
	endtask

	initial begin
		clear_sequencer();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wide_grid_edges();
		test_narrow_grid_edges();
		test_random_traffic();
		test_quiet_finish();
		in_valid <= 1'b0;
		while (step_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
